FILE: src/plpc_pkg.sv
// Shared types, widths and codes for the piecewise linear pixel calibration block.
package plpc_pkg;

    localparam int DATA_W            = 32;
    localparam int COUNT_W           = 4;
    localparam int SEG_IDX_W         = 3;
    localparam int TABLE_DEPTH       = 8;
    localparam int PIXEL_W           = 8;
    localparam int MAG_W             = DATA_W + 1;
    localparam int PROD_W            = 2 * DATA_W + 1;
    localparam int QUOT_W            = 47;
    localparam int VAL_W             = QUOT_W + 2;
    localparam int MUL_LO_W          = 16;
    localparam int DIV_CNT_W         = $clog2(QUOT_W);
    localparam int ROW_W             = 4 * DATA_W;

    localparam int DEF_MAX_SEGMENTS  = 8;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SAT,
        ST_DIV,
        ST_SUM,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_MISSING,
        DP_IDENT,
        DP_BEYOND,
        DP_FLAT,
        DP_OPERANDS,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_SAT,
        DP_DIV,
        DP_SUM,
        DP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [SEG_IDX_W-1:0]   rd_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic missing;
        logic count_zero;
        logic last;
        logic greater;
        logic flat;
        logic saturate;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/plpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/plpc_datapath.sv
// Datapath: segment table, search compare, multiplier, serial divider and output register.
module plpc_datapath #(
    parameter int MAX_SEGMENTS  = plpc_pkg::DEF_MAX_SEGMENTS,
    parameter int FRACTION_BITS = plpc_pkg::DEF_FRACTION_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  plpc_pkg::dp_cmd_t                     cmd,
    output plpc_pkg::dp_status_t                  status,
    input  logic                                  cfg_wr_en,
    input  logic [plpc_pkg::COUNT_W-1:0]          cfg_wr_data,
    input  logic                                  op,
    input  logic signed [plpc_pkg::DATA_W-1:0]    sample_value,
    input  logic                                  sample_missing,
    input  logic [plpc_pkg::SEG_IDX_W-1:0]        segment_index,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_pixel_low,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_pixel_high,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_value_low,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_value_high,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [plpc_pkg::PIXEL_W-1:0]          pixel,
    output logic                                  beyond_table,
    output logic                                  flat_segment
);

    localparam int DW         = plpc_pkg::DATA_W;
    localparam int MW         = plpc_pkg::MAG_W;
    localparam int PW         = plpc_pkg::PROD_W;
    localparam int QW         = plpc_pkg::QUOT_W;
    localparam int VW         = plpc_pkg::VAL_W;
    localparam int LW         = plpc_pkg::MUL_LO_W;
    localparam int CW         = plpc_pkg::COUNT_W;
    localparam int TABLE_ROWS = (MAX_SEGMENTS < plpc_pkg::TABLE_DEPTH) ?
                                MAX_SEGMENTS : plpc_pkg::TABLE_DEPTH;
    localparam int ADDR_W     = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

    function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
        return v[MW-1] ? (~v + MW'(1)) : v;
    endfunction

    // Configuration and captured item.
    logic [CW-1:0]          seg_count_reg;
    logic                   is_load_reg;
    logic                   missing_reg;
    logic signed [DW-1:0]   s_reg;

    // Interpolation operands and arithmetic state.
    logic [MW-1:0]          ma_reg;
    logic [MW-1:0]          mb_reg;
    logic [MW-1:0]          md_reg;
    logic                   neg_reg;
    logic signed [DW-1:0]   pl_reg;
    logic [PW-1:0]          acc_reg;
    logic [MW-1:0]          rem_reg;
    logic [QW-1:0]          quo_reg;
    logic [VW-1:0]          v_reg;
    logic                   beyond_flag_reg;
    logic                   flat_flag_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [plpc_pkg::PIXEL_W-1:0] pixel_reg;
    logic                   beyond_reg;
    logic                   flat_reg;

    logic [plpc_pkg::ROW_W-1:0] wr_row;
    logic [plpc_pkg::ROW_W-1:0] rd_row;
    logic                   ram_wr_en;
    logic signed [DW-1:0]   row_pl;
    logic signed [DW-1:0]   row_ph;
    logic signed [DW-1:0]   row_vl;
    logic signed [DW-1:0]   row_vh;
    logic [CW-1:0]          count_eff;
    logic [MW-1:0]          diff_a;
    logic [MW-1:0]          diff_b;
    logic [MW-1:0]          diff_d;
    logic [LW+MW-1:0]       prod_lo;
    logic [2*MW-LW-1:0]     prod_hi;
    logic [MW-1:0]          acc_top;
    logic [MW:0]            trial;
    logic [MW+1:0]          trial_diff;
    logic                   trial_ge;
    logic [QW:0]            q_ext;
    logic [QW:0]            q_signed;
    logic [VW-1:0]          mag_v;
    logic [VW-1:0]          shifted_v;
    logic [plpc_pkg::PIXEL_W-1:0] pixel_next;

    assign wr_row    = {seg_pixel_low, seg_pixel_high, seg_value_low, seg_value_high};
    assign ram_wr_en = (cmd.op == plpc_pkg::DP_CAPTURE) && (op == plpc_pkg::OP_LOAD) &&
                       (32'(segment_index) < 32'(MAX_SEGMENTS));

    plpc_ram #(
        .WIDTH (plpc_pkg::ROW_W),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (segment_index[ADDR_W-1:0]),
        .wr_data (wr_row),
        .rd_addr (cmd.rd_addr[ADDR_W-1:0]),
        .rd_data (rd_row)
    );

    assign row_pl = rd_row[4*DW-1:3*DW];
    assign row_ph = rd_row[3*DW-1:2*DW];
    assign row_vl = rd_row[2*DW-1:DW];
    assign row_vh = rd_row[DW-1:0];

    assign count_eff = (seg_count_reg > CW'(TABLE_ROWS)) ? CW'(TABLE_ROWS) : seg_count_reg;

    assign diff_a = {s_reg[DW-1], s_reg} - {row_vl[DW-1], row_vl};
    assign diff_b = {row_ph[DW-1], row_ph} - {row_pl[DW-1], row_pl};
    assign diff_d = {row_vh[DW-1], row_vh} - {row_vl[DW-1], row_vl};

    // The 33 by 33 bit product is built from two narrower partial products.
    assign prod_lo = ma_reg * mb_reg[LW-1:0];
    assign prod_hi = ma_reg * mb_reg[MW-1:LW];

    // The quotient exceeds the saturation limit exactly when the bits above it reach the divisor.
    assign acc_top = MW'(acc_reg[PW-1:QW]);

    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign trial_diff = {1'b0, trial} - {2'b00, md_reg};
    assign trial_ge   = ~trial_diff[MW+1];

    assign q_ext    = {1'b0, quo_reg};
    assign q_signed = neg_reg ? (~q_ext + (QW+1)'(1)) : q_ext;

    assign mag_v      = v_reg[VW-1] ? (~v_reg + VW'(1)) : v_reg;
    assign shifted_v  = mag_v >> FRACTION_BITS;
    assign pixel_next = v_reg[VW-1] ? (~shifted_v[plpc_pkg::PIXEL_W-1:0] + 8'd1)
                                    : shifted_v[plpc_pkg::PIXEL_W-1:0];

    always_comb
    begin
        status.is_load    = is_load_reg;
        status.missing    = missing_reg;
        status.count_zero = (count_eff == '0);
        status.last       = ((CW'(cmd.rd_addr) + CW'(1)) >= count_eff);
        status.greater    = (s_reg > row_vh);
        status.flat       = (row_vh == row_vl);
        status.saturate   = (acc_top >= md_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seg_count_reg <= cfg_wr_data;
            end
            if (cmd.op == plpc_pkg::DP_OUTPUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            plpc_pkg::DP_CAPTURE:
            begin
                is_load_reg <= (op == plpc_pkg::OP_LOAD);
                missing_reg <= sample_missing;
                s_reg       <= sample_value;
            end
            plpc_pkg::DP_MISSING:
            begin
                v_reg           <= '0;
                beyond_flag_reg <= 1'b0;
                flat_flag_reg   <= 1'b0;
            end
            plpc_pkg::DP_IDENT:
            begin
                v_reg           <= {{(VW-DW){s_reg[DW-1]}}, s_reg};
                beyond_flag_reg <= 1'b0;
                flat_flag_reg   <= 1'b0;
            end
            plpc_pkg::DP_BEYOND:
            begin
                v_reg           <= {{(VW-DW){s_reg[DW-1]}}, s_reg};
                beyond_flag_reg <= 1'b1;
                flat_flag_reg   <= 1'b0;
            end
            plpc_pkg::DP_FLAT:
            begin
                v_reg           <= {{(VW-DW){row_pl[DW-1]}}, row_pl};
                beyond_flag_reg <= 1'b0;
                flat_flag_reg   <= 1'b1;
            end
            plpc_pkg::DP_OPERANDS:
            begin
                ma_reg          <= mag(diff_a);
                mb_reg          <= mag(diff_b);
                md_reg          <= mag(diff_d);
                neg_reg         <= diff_a[MW-1] ^ diff_b[MW-1] ^ diff_d[MW-1];
                pl_reg          <= row_pl;
                beyond_flag_reg <= 1'b0;
                flat_flag_reg   <= 1'b0;
            end
            plpc_pkg::DP_MUL_LO:
            begin
                acc_reg <= PW'(prod_lo);
            end
            plpc_pkg::DP_MUL_HI:
            begin
                acc_reg <= acc_reg + PW'({prod_hi, {LW{1'b0}}});
            end
            plpc_pkg::DP_SAT:
            begin
                if (acc_top >= md_reg)
                begin
                    quo_reg <= '1;
                end
                else
                begin
                    rem_reg <= acc_top;
                    quo_reg <= acc_reg[QW-1:0];
                end
            end
            plpc_pkg::DP_DIV:
            begin
                rem_reg <= trial_ge ? trial_diff[MW-1:0] : trial[MW-1:0];
                quo_reg <= {quo_reg[QW-2:0], trial_ge};
            end
            plpc_pkg::DP_SUM:
            begin
                v_reg <= {{(VW-DW){pl_reg[DW-1]}}, pl_reg} + {q_signed[QW], q_signed};
            end
            plpc_pkg::DP_OUTPUT:
            begin
                pixel_reg  <= pixel_next;
                beyond_reg <= beyond_flag_reg;
                flat_reg   <= flat_flag_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign pixel        = pixel_reg;
    assign beyond_table = beyond_reg;
    assign flat_segment = flat_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == plpc_pkg::DP_DIV) |-> (rem_reg < md_reg))
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == plpc_pkg::DP_OUTPUT) |=> out_valid_reg)
        else $error("output register not valid after load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == plpc_pkg::DP_SAT && status.saturate) |=> (quo_reg == '1))
        else $error("saturated quotient not at limit");
`endif

endmodule

FILE: src/plpc_controller.sv
// Controller state machine: sequences capture, segment search, multiply, divide and output.
module plpc_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  plpc_pkg::dp_status_t  status,
    output plpc_pkg::dp_cmd_t     cmd
);

    plpc_pkg::state_t                   state_reg;
    plpc_pkg::state_t                   state_next;
    logic [plpc_pkg::SEG_IDX_W-1:0]     n_reg;
    logic [plpc_pkg::SEG_IDX_W-1:0]     n_next;
    logic [plpc_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic [plpc_pkg::DIV_CNT_W-1:0]     div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= plpc_pkg::ST_IDLE;
            n_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = plpc_pkg::DP_NONE;
        cmd.rd_addr  = n_reg;
        in_stall     = 1'b1;

        case (state_reg)
            plpc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = plpc_pkg::DP_CAPTURE;
                    state_next = plpc_pkg::ST_DECIDE;
                end
            end
            plpc_pkg::ST_DECIDE:
            begin
                n_next = '0;
                if (status.is_load)
                begin
                    state_next = plpc_pkg::ST_IDLE;
                end
                else if (status.missing)
                begin
                    cmd.op     = plpc_pkg::DP_MISSING;
                    state_next = plpc_pkg::ST_FINISH;
                end
                else if (status.count_zero)
                begin
                    cmd.op     = plpc_pkg::DP_IDENT;
                    state_next = plpc_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = plpc_pkg::ST_READ;
                end
            end
            plpc_pkg::ST_READ:
            begin
                state_next = plpc_pkg::ST_CHECK;
            end
            plpc_pkg::ST_CHECK:
            begin
                if (status.greater)
                begin
                    if (status.last)
                    begin
                        cmd.op     = plpc_pkg::DP_BEYOND;
                        state_next = plpc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = plpc_pkg::ST_READ;
                    end
                end
                else if (status.flat)
                begin
                    cmd.op     = plpc_pkg::DP_FLAT;
                    state_next = plpc_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.op     = plpc_pkg::DP_OPERANDS;
                    state_next = plpc_pkg::ST_MUL_LO;
                end
            end
            plpc_pkg::ST_MUL_LO:
            begin
                cmd.op     = plpc_pkg::DP_MUL_LO;
                state_next = plpc_pkg::ST_MUL_HI;
            end
            plpc_pkg::ST_MUL_HI:
            begin
                cmd.op     = plpc_pkg::DP_MUL_HI;
                state_next = plpc_pkg::ST_SAT;
            end
            plpc_pkg::ST_SAT:
            begin
                cmd.op       = plpc_pkg::DP_SAT;
                div_cnt_next = '0;
                state_next   = status.saturate ? plpc_pkg::ST_SUM : plpc_pkg::ST_DIV;
            end
            plpc_pkg::ST_DIV:
            begin
                cmd.op = plpc_pkg::DP_DIV;
                if (div_cnt_reg == plpc_pkg::DIV_CNT_W'(plpc_pkg::QUOT_W - 1))
                begin
                    state_next = plpc_pkg::ST_SUM;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            plpc_pkg::ST_SUM:
            begin
                cmd.op     = plpc_pkg::DP_SUM;
                state_next = plpc_pkg::ST_FINISH;
            end
            plpc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = plpc_pkg::DP_OUTPUT;
                    state_next = plpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plpc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plpc_pkg::ST_IDLE && in_valid) |=> (state_reg == plpc_pkg::ST_DECIDE))
        else $error("accepted transaction not captured");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plpc_pkg::ST_DIV &&
         div_cnt_reg == plpc_pkg::DIV_CNT_W'(plpc_pkg::QUOT_W - 1))
        |=> (state_reg == plpc_pkg::ST_SUM))
        else $error("divider did not finish after the last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plpc_pkg::ST_CHECK && status.greater && !status.last)
        |=> (state_reg == plpc_pkg::ST_READ && n_reg == $past(n_reg) + 3'd1))
        else $error("segment search did not advance");
`endif

endmodule

FILE: src/piecewise_linear_pixel_calibration_unit.sv
// Top level of the piecewise linear pixel calibration block.
//
// Input channel (in_valid / in_stall): one transaction is either a segment
// load (op = 1), which writes one table slot and gives no result, or a
// sample conversion (op = 0), which gives exactly one result on the output
// channel (out_valid / out_stall): pixel, beyond_table and flat_segment.
// segment_count is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Items are handled one at a time. A conversion ends without a search when the
// sample is missing or no segments are in use, ends at segment k on a flat
// segment or beyond the table, skips the 47-step serial divider when the
// interpolated term saturates, and runs it otherwise; each search step per
// segment is a registered table read, then a compare.
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver keeps stalling, a second finished result
// waits inside the block and the input channel stalls until it can move.
// Reset clears the state machine, the output valid and segment_count; the
// table holds nothing defined until its slots are loaded.
module piecewise_linear_pixel_calibration_unit #(
    parameter int MAX_SEGMENTS  = plpc_pkg::DEF_MAX_SEGMENTS,
    parameter int FRACTION_BITS = plpc_pkg::DEF_FRACTION_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [plpc_pkg::COUNT_W-1:0]          cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic signed [plpc_pkg::DATA_W-1:0]    sample_value,
    input  logic                                  sample_missing,
    input  logic [plpc_pkg::SEG_IDX_W-1:0]        segment_index,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_pixel_low,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_pixel_high,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_value_low,
    input  logic signed [plpc_pkg::DATA_W-1:0]    seg_value_high,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [plpc_pkg::PIXEL_W-1:0]          pixel,
    output logic                                  beyond_table,
    output logic                                  flat_segment
);

    plpc_pkg::dp_cmd_t    cmd;
    plpc_pkg::dp_status_t status;

    plpc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    plpc_datapath #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .op             (op),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .segment_index  (segment_index),
        .seg_pixel_low  (seg_pixel_low),
        .seg_pixel_high (seg_pixel_high),
        .seg_value_low  (seg_value_low),
        .seg_value_high (seg_value_high),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .pixel          (pixel),
        .beyond_table   (beyond_table),
        .flat_segment   (flat_segment)
    );

endmodule

FILE: sim/piecewise_linear_pixel_calibration_unit_test.sv
// Self-checking testbench for the piecewise linear pixel calibration unit.
module piecewise_linear_pixel_calibration_unit_test;
    import plpc_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 100;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 66;
    localparam int PHASES         = 8;
    localparam logic [127:0] QUOT_LIMIT = 128'h7FFF_FFFF_FFFF;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] sample;
        logic                     missing;
        logic [SEG_IDX_W-1:0]     slot;
        logic signed [DATA_W-1:0] pixel_lo;
        logic signed [DATA_W-1:0] pixel_hi;
        logic signed [DATA_W-1:0] value_lo;
        logic signed [DATA_W-1:0] value_hi;
    } calib_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic               beyond;
        logic               flat;
    } pixel_result_t;

    logic                     clk;
    logic                     rst_n          = 1'b0;
    logic                     cfg_wr_en      = 1'b0;
    logic [COUNT_W-1:0]       cfg_wr_data    = '0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic                     op             = OP_CONVERT;
    logic signed [DATA_W-1:0] sample_value   = '0;
    logic                     sample_missing = 1'b0;
    logic [SEG_IDX_W-1:0]     segment_index  = '0;
    logic signed [DATA_W-1:0] seg_pixel_low  = '0;
    logic signed [DATA_W-1:0] seg_pixel_high = '0;
    logic signed [DATA_W-1:0] seg_value_low  = '0;
    logic signed [DATA_W-1:0] seg_value_high = '0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic [PIXEL_W-1:0]       pixel;
    logic                     beyond_table;
    logic                     flat_segment;

    // Value bounds as the stimulus planner sees them, used to aim samples at segments.
    logic signed [DATA_W-1:0] plan_value_low  [TABLE_DEPTH];
    logic signed [DATA_W-1:0] plan_value_high [TABLE_DEPTH];
    int                       plan_count;

    // Calibration table and segment count as the predictor tracks them.
    logic signed [DATA_W-1:0] cal_pixel_low  [TABLE_DEPTH];
    logic signed [DATA_W-1:0] cal_pixel_high [TABLE_DEPTH];
    logic signed [DATA_W-1:0] cal_value_low  [TABLE_DEPTH];
    logic signed [DATA_W-1:0] cal_value_high [TABLE_DEPTH];
    int                       cal_count;

    calib_item_t   pending_items [$];
    pixel_result_t expected_pixels [$];

    bit idling_off;
    bit long_hold_due;
    int send_gap;
    int stall_left;
    int hold_left;
    int quiet_cycles;
    int error_count;
    int conversions_checked;
    int missing_seen;
    int beyond_seen;
    int flat_seen;
    int loads_applied;
    int settings_used;

    piecewise_linear_pixel_calibration_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .segment_index  (segment_index),
        .seg_pixel_low  (seg_pixel_low),
        .seg_pixel_high (seg_pixel_high),
        .seg_value_low  (seg_value_low),
        .seg_value_high (seg_value_high),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel          (pixel),
        .beyond_table   (beyond_table),
        .flat_segment   (flat_segment)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer part of a fixed-point value, truncated toward zero, low byte only.
    function automatic logic [PIXEL_W-1:0] pixel_byte(longint v);
        longint m;
        m = ((v < 0) ? -v : v) >>> DEF_FRACTION_BITS;
        if (v < 0)
            m = -m;
        return m[PIXEL_W-1:0];
    endfunction

    function automatic pixel_result_t predict_pixel(logic signed [DATA_W-1:0] s,
                                                    logic missing);
        pixel_result_t r;
        int            lim;
        int            k;
        longint        a;
        longint        b;
        longint        d;
        logic [63:0]   ma;
        logic [63:0]   mb;
        logic [63:0]   md;
        logic [127:0]  q;
        logic          neg;
        r = '0;
        if (missing)
            return r;
        lim = (cal_count > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : cal_count;
        k = 0;
        while (k < lim && s > cal_value_high[k])
            k++;
        if (lim == 0)
            r.px = pixel_byte(s);
        else if (k >= lim)
        begin
            r.px = pixel_byte(s);
            r.beyond = 1'b1;
        end
        else if (cal_value_high[k] == cal_value_low[k])
        begin
            r.px = pixel_byte(cal_pixel_low[k]);
            r.flat = 1'b1;
        end
        else
        begin
            a = longint'(s) - longint'(cal_value_low[k]);
            b = longint'(cal_pixel_high[k]) - longint'(cal_pixel_low[k]);
            d = longint'(cal_value_high[k]) - longint'(cal_value_low[k]);
            neg = ((a < 0) != (b < 0)) != (d < 0);
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            md = (d < 0) ? -d : d;
            // The exact product needs up to 64 bits before the division.
            q = ({64'b0, ma} * {64'b0, mb}) / {64'b0, md};
            if (q > QUOT_LIMIT)
                q = QUOT_LIMIT;
            r.px = pixel_byte(longint'(cal_pixel_low[k]) +
                              (neg ? -longint'(q[63:0]) : longint'(q[63:0])));
        end
        return r;
    endfunction

    task automatic queue_conversion(logic signed [DATA_W-1:0] s, logic missing);
        calib_item_t it;
        it.op       = OP_CONVERT;
        it.sample   = s;
        it.missing  = missing;
        it.slot     = SEG_IDX_W'($urandom());
        it.pixel_lo = $urandom();
        it.pixel_hi = $urandom();
        it.value_lo = $urandom();
        it.value_hi = $urandom();
        pending_items.push_back(it);
    endtask

    task automatic queue_load(logic [SEG_IDX_W-1:0] slot,
                              logic signed [DATA_W-1:0] pl, logic signed [DATA_W-1:0] ph,
                              logic signed [DATA_W-1:0] vl, logic signed [DATA_W-1:0] vh);
        calib_item_t it;
        it.op       = OP_LOAD;
        it.sample   = $urandom();
        it.missing  = 1'($urandom_range(0, 1));
        it.slot     = slot;
        it.pixel_lo = pl;
        it.pixel_hi = ph;
        it.value_lo = vl;
        it.value_hi = vh;
        pending_items.push_back(it);
        plan_value_low[slot]  = vl;
        plan_value_high[slot] = vh;
    endtask

    task automatic queue_random_load(int slot);
        queue_load(SEG_IDX_W'(slot), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Contiguous ascending segments with mostly byte-range pixels and a few flat ones.
    task automatic plan_ramp_table();
        int unsigned              step;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] pl;
        logic signed [DATA_W-1:0] ph;
        int                       k;
        step = $urandom_range(1, 32'h0FFF_FFFF) >> $urandom_range(0, 27);
        if (step == 0)
            step = 1;
        lo = -int'(4 * step) + int'($urandom_range(0, step - 1));
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                pl = $urandom();
                ph = $urandom();
            end
            else
            begin
                pl = $urandom_range(0, 32'h00FF_FFFF);
                ph = $urandom_range(0, 32'h00FF_FFFF);
            end
            hi = ($urandom_range(0, 7) == 0) ? lo : lo + int'(step) - 1;
            queue_load(SEG_IDX_W'(k), pl, ph, lo, hi);
            lo = lo + int'(step);
        end
    endtask

    task automatic plan_sample();
        int                       lim;
        int                       k;
        int                       pick;
        int unsigned              span;
        logic signed [DATA_W-1:0] s;
        lim  = (plan_count > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : plan_count;
        k    = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
        pick = $urandom_range(0, 19);
        s    = $urandom();
        if (pick == 0)
            queue_conversion(s, 1'b1);
        else
        begin
            if (lim != 0)
            begin
                if (pick == 3)
                    s = plan_value_high[k];
                else if (pick == 4)
                    s = plan_value_high[k] + 1;
                else if (pick == 5)
                    s = plan_value_high[lim - 1] + $urandom_range(1, 32'h0001_0000);
                else if (pick > 5 && plan_value_high[k] >= plan_value_low[k])
                begin
                    span = plan_value_high[k] - plan_value_low[k];
                    s = plan_value_low[k] + $urandom_range(0, span);
                end
            end
            queue_conversion(s, 1'b0);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // A load gives no result, so the block may still be busy after the last pixel.
    task automatic apply_segment_count(int c);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(c);
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        cal_count  = c;
        plan_count = c;
        settings_used++;
    endtask

    always @(posedge clk)
    begin : drive_items
        if (in_valid && !in_stall)
            pending_items.delete(0);
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_stall))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!idling_off && pending_items.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 14);
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_valid       <= 1'b1;
                op             <= pending_items[0].op;
                sample_value   <= pending_items[0].sample;
                sample_missing <= pending_items[0].missing;
                segment_index  <= pending_items[0].slot;
                seg_pixel_low  <= pending_items[0].pixel_lo;
                seg_pixel_high <= pending_items[0].pixel_hi;
                seg_value_low  <= pending_items[0].value_lo;
                seg_value_high <= pending_items[0].value_hi;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : stall_outputs
        if (long_hold_due)
        begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!idling_off && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_result_t want;
        pixel_result_t got;
        if (rst_n)
        begin
            // Results are compared before this edge's input transaction is predicted.
            if (out_valid && !out_stall)
            begin
                got = {pixel, beyond_table, flat_segment};
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("Unexpected result: pixel %0d beyond %0b flat %0b",
                                 pixel, beyond_table, flat_segment);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    conversions_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"Mismatch on result %0d: expected pixel %0d beyond %0b ",
                                      "flat %0b, got pixel %0d beyond %0b flat %0b"},
                                     conversions_checked, want.px, want.beyond, want.flat,
                                     pixel, beyond_table, flat_segment);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (op == OP_LOAD)
                begin
                    cal_pixel_low[segment_index]  = seg_pixel_low;
                    cal_pixel_high[segment_index] = seg_pixel_high;
                    cal_value_low[segment_index]  = seg_value_low;
                    cal_value_high[segment_index] = seg_value_high;
                    loads_applied++;
                end
                else
                begin
                    want = predict_pixel(sample_value, sample_missing);
                    expected_pixels.push_back(want);
                    missing_seen += sample_missing;
                    beyond_seen  += want.beyond;
                    flat_seen    += want.flat;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("No transaction for %0d cycles, stopping.", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int settings [PHASES];
        int p;
        int n;
        int k;
        settings = '{8, 0, 15, 3, 1, 6, 9, 8};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Identity mapping at the extremes of the sample, then a missing sample.
        apply_segment_count(0);
        queue_conversion(32'sh0000_0000, 1'b0);
        queue_conversion(32'sh7FFF_FFFF, 1'b0);
        queue_conversion(32'sh8000_0000, 1'b0);
        queue_conversion(32'shFFFF_FFFF, 1'b0);
        queue_conversion(32'shFFFF_0000, 1'b0);
        queue_conversion($urandom(), 1'b1);

        // Every slot gets written; slot 0 then has reversed one-step value bounds so
        // the interpolated term saturates, and slot 1 is a flat segment at the top.
        plan_ramp_table();
        queue_load(SEG_IDX_W'(0), 32'sh0010_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFE);
        queue_load(SEG_IDX_W'(1), 32'sh00C8_0000, $urandom(), 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF);
        apply_segment_count(1);
        queue_conversion(32'sh8000_0000, 1'b0);
        queue_conversion(32'sh7FFF_FFFF, 1'b0);
        queue_conversion(32'sh7FFF_FFFE, 1'b0);
        queue_load(SEG_IDX_W'(0), 32'sh0010_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFE);
        queue_conversion(32'sh8000_0000, 1'b0);
        apply_segment_count(2);
        queue_conversion(32'sh7FFF_FFFF, 1'b0);

        for (p = 0; p < PHASES; p++)
        begin
            apply_segment_count(settings[p]);
            idling_off = (p == 3 || p == PHASES - 1);
            if (p == 2)
                long_hold_due = 1'b1;
            if (p == 4 || $urandom_range(0, 3) == 0)
            begin
                for (k = 0; k < TABLE_DEPTH; k++)
                    queue_random_load(k);
            end
            else
                plan_ramp_table();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    queue_random_load($urandom_range(0, TABLE_DEPTH - 1));
                else
                    plan_sample();
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d conversions (%0d missing, %0d beyond the table, %0d flat) and %0d loads,",
                 conversions_checked, missing_seen, beyond_seen, flat_seen, loads_applied);
        $display("over %0d segment_count settings with random and long output holds.",
                 settings_used);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
